>>> src/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared codes and constants of the first-fit boundary tag allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffa_pkg;

	typedef enum logic [0:0] {
		KIND_ALLOC = 1'b0,
		KIND_FREE  = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_OK   = 2'd0,
		STATUS_NULL = 2'd1,
		STATUS_OOM  = 2'd2
	} status_t;

	localparam int HEAP_BASE   = 12;
	localparam int TAG_BYTES   = 4;
	localparam int ALIGN_BYTES = 8;

endpackage

`default_nettype wire

>>> src/ffa_ram.sv
// ----------------------------------------------------------------------------
// ffa_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> src/first_fit_boundary_tag_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_boundary_tag_allocator
// Heap allocator over boundary tags kept in one tag RAM, first-fit search.
// ----------------------------------------------------------------------------
// One transaction is taken while busy is low; its single result appears one
// cycle wide with valid and cannot be held off. After reset the block writes
// the prologue and epilogue tags. The cost of a transaction is set by the
// walk over the tag RAM, each block read, then evaluated: an allocate walks
// the blocks passed, then writes tags to split and mark, and each heap growth
// writes new tags and walks afresh from the heap start. A free walks the
// blocks up to the target, reads the next tag and writes the merged tags. A
// zero-size request answers straight from idle, with no walk. Tag RAM entries
// above the epilogue are never read, so no clearing pass follows reset.
`default_nettype none

module first_fit_boundary_tag_allocator #(
	parameter int HEAP_BYTES  = 65536,
	parameter int CHUNK_BYTES = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        kind,
	input  wire logic [15:0] request_size,
	input  wire logic [15:0] free_address,
	output logic             valid,
	output logic      [15:0] payload_address,
	output logic      [1:0]  status
);

	import ffa_pkg::*;

	localparam int AW    = $clog2(HEAP_BYTES);
	localparam int WAW   = AW - 2;
	localparam int DW    = AW - 2;
	localparam int DEPTH = HEAP_BYTES / 4;
	localparam int WW    = ((AW > 18) ? AW : 18) + 2;

	typedef enum logic [3:0] {
		ST_INIT, ST_IDLE, ST_ARD, ST_AEV, ST_GROW,
		ST_FRD, ST_FEV, ST_NRD, ST_NEV, ST_WR
	} state_t;

	function automatic logic [WW-1:0] tag_size(input logic [DW-1:0] t);
		return WW'({t[DW-1:1], 3'b000});
	endfunction

	function automatic logic [DW-1:0] mk_tag(input logic [WW-1:0] sz, input logic used);
		return {sz[AW-1:3], used};
	endfunction

	state_t           state_q;
	logic [1:0]       w_idx_q;
	logic [1:0]       w_last_q;
	logic             restart_q;
	logic [WW-1:0]    wa_q [4];
	logic [DW-1:0]    wd_q [4];
	logic [WW-1:0]    b_q;
	logic [WW-1:0]    epi_q;
	logic [WW-1:0]    need_q;
	logic [WW-1:0]    sz_q;
	logic [WW-1:0]    prev_b_q;
	logic [WW-1:0]    prev_sz_q;
	logic             prev_free_q;
	logic [15:0]      addr_q;
	logic [15:0]      res_pay_q;
	logic             valid_q;
	logic [15:0]      pay_q;
	status_t          status_q;

	logic             we;
	logic [WAW-1:0]   waddr;
	logic [DW-1:0]    wdata;
	logic [WAW-1:0]   raddr;
	logic [DW-1:0]    rdata;
	logic [WW-1:0]    tsz;
	logic             tfree;
	logic [WW-1:0]    rsz;
	logic [WW-1:0]    mblk;
	logic [WW-1:0]    msz;
	logic [WW-1:0]    nepi;
	logic [WW-1:0]    cur;

	ffa_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_tags (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		tsz   = tag_size(rdata);
		tfree = !rdata[0];
		rsz   = tsz - need_q - WW'(ALIGN_BYTES);
		nepi  = epi_q + WW'(CHUNK_BYTES);
		cur   = b_q + WW'(TAG_BYTES);
		msz   = sz_q + (tfree ? tsz : '0) + (prev_free_q ? prev_sz_q : '0);
		mblk  = prev_free_q ? prev_b_q : b_q;
		raddr = (state_q == ST_NRD) ? WAW'((b_q + sz_q) >> 2) : WAW'(b_q >> 2);
		we    = 1'b0;
		waddr = WAW'(wa_q[w_idx_q] >> 2);
		wdata = wd_q[w_idx_q];
		case (state_q)
			ST_INIT: begin
				we    = 1'b1;
				waddr = WAW'(w_idx_q) + WAW'(1);
				wdata = mk_tag(WW'(ALIGN_BYTES), 1'b1);
			end
			ST_WR: begin
				we = 1'b1;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			w_idx_q     <= '0;
			w_last_q    <= '0;
			restart_q   <= 1'b0;
			epi_q       <= WW'(HEAP_BASE);
			prev_free_q <= 1'b0;
			valid_q     <= 1'b0;
			pay_q       <= '0;
			status_q    <= STATUS_OK;
		end else begin
			valid_q <= 1'b0;
			case (state_q)
				ST_INIT: begin
					w_idx_q <= w_idx_q + 2'd1;
					if (w_idx_q == 2'd3) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						b_q         <= WW'(HEAP_BASE);
						prev_free_q <= 1'b0;
						addr_q      <= free_address;
						need_q      <= (WW'(request_size) + WW'(7)) & ~WW'(7);
						if (kind == KIND_FREE) begin
							state_q <= ST_FRD;
						end else if (request_size == 16'd0) begin
							valid_q  <= 1'b1;
							pay_q    <= '0;
							status_q <= STATUS_NULL;
						end else begin
							state_q <= ST_ARD;
						end
					end
				end
				ST_ARD: begin
					state_q <= (b_q == epi_q) ? ST_GROW : ST_AEV;
				end
				ST_AEV: begin
					if (tsz == '0) begin
						state_q <= ST_GROW;
					end else if (tfree && tsz >= need_q + WW'(8)) begin
						restart_q <= 1'b0;
						res_pay_q <= cur[15:0];
						w_idx_q   <= '0;
						state_q   <= ST_WR;
						if (tsz > need_q + WW'(16)) begin
							wa_q[0]  <= b_q;
							wd_q[0]  <= mk_tag(need_q + WW'(8), 1'b1);
							wa_q[1]  <= b_q + need_q + WW'(4);
							wd_q[1]  <= mk_tag(need_q + WW'(8), 1'b1);
							wa_q[2]  <= b_q + need_q + WW'(8);
							wd_q[2]  <= mk_tag(rsz, 1'b0);
							wa_q[3]  <= b_q + tsz - WW'(4);
							wd_q[3]  <= mk_tag(rsz, 1'b0);
							w_last_q <= 2'd3;
						end else begin
							wa_q[0]  <= b_q;
							wd_q[0]  <= mk_tag(tsz, 1'b1);
							wa_q[1]  <= b_q + tsz - WW'(4);
							wd_q[1]  <= mk_tag(tsz, 1'b1);
							w_last_q <= 2'd1;
						end
					end else begin
						prev_b_q    <= b_q;
						prev_sz_q   <= tsz;
						prev_free_q <= tfree;
						b_q         <= b_q + tsz;
						state_q     <= ST_ARD;
					end
				end
				ST_GROW: begin
					if (nepi + WW'(8) > WW'(HEAP_BYTES)) begin
						valid_q  <= 1'b1;
						pay_q    <= '0;
						status_q <= STATUS_OOM;
						state_q  <= ST_IDLE;
					end else begin
						if (prev_free_q) begin
							wa_q[0] <= prev_b_q;
							wd_q[0] <= mk_tag(prev_sz_q + WW'(CHUNK_BYTES), 1'b0);
							wd_q[1] <= mk_tag(prev_sz_q + WW'(CHUNK_BYTES), 1'b0);
						end else begin
							wa_q[0] <= epi_q;
							wd_q[0] <= mk_tag(WW'(CHUNK_BYTES), 1'b0);
							wd_q[1] <= mk_tag(WW'(CHUNK_BYTES), 1'b0);
						end
						wa_q[1]   <= nepi - WW'(4);
						wa_q[2]   <= nepi;
						wd_q[2]   <= mk_tag(WW'(ALIGN_BYTES), 1'b1);
						wa_q[3]   <= nepi + WW'(4);
						wd_q[3]   <= mk_tag(WW'(ALIGN_BYTES), 1'b1);
						w_last_q  <= 2'd3;
						w_idx_q   <= '0;
						restart_q <= 1'b1;
						epi_q     <= nepi;
						state_q   <= ST_WR;
					end
				end
				ST_FRD: begin
					if (b_q == epi_q) begin
						valid_q  <= 1'b1;
						pay_q    <= '0;
						status_q <= STATUS_OK;
						state_q  <= ST_IDLE;
					end else begin
						state_q <= ST_FEV;
					end
				end
				ST_FEV: begin
					if (tsz != '0 && cur == WW'(addr_q) && !tfree) begin
						sz_q    <= tsz;
						state_q <= ST_NRD;
					end else if (tsz == '0 || cur >= WW'(addr_q)) begin
						valid_q  <= 1'b1;
						pay_q    <= '0;
						status_q <= STATUS_OK;
						state_q  <= ST_IDLE;
					end else begin
						prev_b_q    <= b_q;
						prev_sz_q   <= tsz;
						prev_free_q <= tfree;
						b_q         <= b_q + tsz;
						state_q     <= ST_FRD;
					end
				end
				ST_NRD: begin
					state_q <= ST_NEV;
				end
				ST_NEV: begin
					wa_q[0]   <= mblk;
					wd_q[0]   <= mk_tag(msz, 1'b0);
					wa_q[1]   <= mblk + msz - WW'(4);
					wd_q[1]   <= mk_tag(msz, 1'b0);
					w_last_q  <= 2'd1;
					w_idx_q   <= '0;
					restart_q <= 1'b0;
					res_pay_q <= '0;
					state_q   <= ST_WR;
				end
				ST_WR: begin
					w_idx_q <= w_idx_q + 2'd1;
					if (w_idx_q == w_last_q) begin
						if (restart_q) begin
							b_q         <= WW'(HEAP_BASE);
							prev_free_q <= 1'b0;
							state_q     <= ST_ARD;
						end else begin
							valid_q  <= 1'b1;
							pay_q    <= res_pay_q;
							status_q <= STATUS_OK;
							state_q  <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy            = (state_q != ST_IDLE);
	assign valid           = valid_q;
	assign payload_address = pay_q;
	assign status          = status_q;

	a_zero_size_null: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && kind == KIND_ALLOC && request_size == 16'd0
		|=> valid && status == STATUS_NULL)
		else $error("zero-size request did not return null");

	a_payload_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> payload_address[2:0] == 3'b000)
		else $error("payload address is not 8-byte aligned");

	a_epi_in_heap: assert property (@(posedge clk) disable iff (!arst_n)
		epi_q + WW'(8) <= WW'(HEAP_BYTES))
		else $error("epilogue lies beyond the heap");

	a_epi_grows: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_GROW |=> epi_q == $past(epi_q))
		else $error("epilogue moved outside a growth step");

endmodule

`default_nettype wire

>>> test/first_fit_boundary_tag_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_boundary_tag_allocator_tb
// Sends allocate and free transactions to the allocator and compares each
// result with a behavioral boundary tag heap kept in the testbench.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_boundary_tag_allocator_tb;
	import ffa_pkg::*;

	localparam int HEAP_SZ  = 65536;
	localparam int CHUNK_SZ = 4096;
	localparam int WORDS    = HEAP_SZ / 4;
	localparam int WD_LIMIT = 500000;

	typedef struct packed {
		kind_t       op;
		logic [15:0] req_size;
		logic [15:0] addr;
	} heap_op_t;

	typedef struct packed {
		logic [15:0] payload;
		status_t     st;
	} heap_answer_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic        kind = 1'b0;
	logic [15:0] request_size = '0;
	logic [15:0] free_address = '0;
	logic        valid;
	logic [15:0] payload_address;
	logic [1:0]  status;

	first_fit_boundary_tag_allocator #(
		.HEAP_BYTES(HEAP_SZ),
		.CHUNK_BYTES(CHUNK_SZ)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.request_size(request_size),
		.free_address(free_address),
		.valid(valid),
		.payload_address(payload_address),
		.status(status)
	);

	always #6 clk = ~clk;

	logic [31:0]  tags [WORDS];
	logic [31:0]  epi_off;
	heap_op_t     pending_ops [$];
	heap_op_t     pending_driven [$];
	heap_answer_t expected_answers [$];
	logic [15:0]  live_blocks [$];
	logic         busy_at_edge = 1'b0;
	int           errors = 0;
	int           n_alloc = 0, n_free = 0, n_oom = 0, n_null = 0;
	int           quiet_cycles = 0;
	bit           no_idle = 1'b0;
	bit           stim_done = 1'b0;

	function automatic logic [31:0] tag_get(logic [31:0] off);
		return (off / 4 < WORDS) ? tags[off / 4] : 32'd0;
	endfunction

	task automatic tag_put(logic [31:0] off, logic [31:0] v);
		if (off / 4 < WORDS)
			tags[off / 4] = v;
	endtask

	task automatic mark(logic [31:0] blk, logic [31:0] sz, logic flag);
		tag_put(blk, sz | flag);
		tag_put(blk + sz - 4, sz | flag);
	endtask

	task automatic coalesce(logic [31:0] blk);
		logic [31:0] sz, nxt, prv, nt, pt;
		sz = tag_get(blk) & ~32'd7;
		nxt = blk + sz;
		prv = blk - (tag_get(blk - 4) & ~32'd7);
		nt = tag_get(nxt);
		pt = tag_get(prv);
		if (!nt[0])
			sz += nt & ~32'd7;
		if (!pt[0]) begin
			sz += pt & ~32'd7;
			blk = prv;
		end
		mark(blk, sz, 1'b0);
	endtask

	task automatic heap_reset();
		foreach (tags[i])
			tags[i] = '0;
		mark(4, 8, 1'b1);
		mark(HEAP_BASE, 8, 1'b1);
		epi_off = HEAP_BASE;
	endtask

	task automatic seek_fit(logic [31:0] need, output logic [31:0] found);
		logic [31:0] b, t, sz;
		found = 0;
		b = HEAP_BASE;
		while (b != epi_off && b < HEAP_SZ) begin
			t = tag_get(b);
			sz = t & ~32'd7;
			if (sz == 0)
				break;
			if (!t[0] && sz >= need + 8) begin
				if (sz > need + 16) begin
					mark(b, need + 8, 1'b1);
					mark(b + need + 8, sz - need - 8, 1'b0);
				end else begin
					mark(b, sz, 1'b1);
				end
				found = b;
				return;
			end
			b += sz;
		end
	endtask

	task automatic predict_heap(heap_op_t op, output heap_answer_t ans);
		logic [31:0] need, b, t, sz, old;
		ans.payload = '0;
		ans.st = STATUS_OK;
		if (op.op == KIND_ALLOC) begin
			if (op.req_size == 0) begin
				ans.st = STATUS_NULL;
				return;
			end
			need = (op.req_size + 32'd7) & ~32'd7;
			forever begin
				seek_fit(need, b);
				if (b != 0) begin
					ans.payload = b[15:0] + 16'd4;
					return;
				end
				old = epi_off;
				if (old + 8 + CHUNK_SZ > HEAP_SZ) begin
					ans.st = STATUS_OOM;
					return;
				end
				mark(old, CHUNK_SZ, 1'b0);
				epi_off = old + CHUNK_SZ;
				mark(epi_off, 8, 1'b1);
				coalesce(old);
			end
		end else begin
			b = HEAP_BASE;
			while (b != epi_off && b < HEAP_SZ) begin
				t = tag_get(b);
				sz = t & ~32'd7;
				if (sz == 0)
					break;
				if (b + 4 == op.addr) begin
					if (t[0])
						coalesce(b);
					break;
				end
				if (b + 4 > op.addr)
					break;
				b += sz;
			end
		end
	endtask

	task automatic report(string what, logic [15:0] got, logic [15:0] want);
		errors++;
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
	endtask

	// Driver: picks the next transaction at the falling edge; the monitor predicts it when accepted.
	heap_op_t    cur_op;
	logic [15:0] picked;
	int          li;
	always @(negedge clk) begin
		if (arst_n) begin
			if ((!start || !busy_at_edge) && pending_ops.size() > 0
					&& (no_idle || $urandom_range(99) >= 10)) begin
				cur_op = pending_ops.pop_front();
				// Free addresses marked 0 take a random live block when one exists.
				if (cur_op.op == KIND_FREE && cur_op.addr == 16'd0 && live_blocks.size() > 0) begin
					li = $urandom_range(live_blocks.size() - 1);
					cur_op.addr = live_blocks[li];
					live_blocks.delete(li);
				end
				pending_driven.push_back(cur_op);
				start <= 1'b1;
				kind <= cur_op.op;
				request_size <= cur_op.req_size;
				free_address <= cur_op.addr;
			end else if (start && !busy_at_edge) begin
				start <= 1'b0;
			end
		end
	end

	heap_answer_t ans;
	heap_op_t     acc_op;

	// Monitor: accepts transactions and results at the rising edge.
	always @(posedge clk) begin
		busy_at_edge <= busy;
		if (arst_n) begin
			quiet_cycles++;
			if (start && !busy) begin
				acc_op = pending_driven.pop_front();
				predict_heap(acc_op, ans);
				expected_answers.push_back(ans);
				if (acc_op.op == KIND_FREE)
					n_free++;
				else if (ans.st == STATUS_OK)
					n_alloc++;
				else if (ans.st == STATUS_OOM)
					n_oom++;
				else
					n_null++;
				if (acc_op.op == KIND_ALLOC && ans.st == STATUS_OK)
					live_blocks.push_back(ans.payload);
				quiet_cycles = 0;
			end
			if (valid) begin
				quiet_cycles = 0;
				if (expected_answers.size() == 0) begin
					report("unexpected result", payload_address, 16'd0);
				end else begin
					ans = expected_answers.pop_front();
					if (payload_address !== ans.payload)
						report("payload_address", payload_address, ans.payload);
					if (status !== ans.st)
						report("status", {14'd0, status}, {14'd0, ans.st});
				end
			end
			if (quiet_cycles >= WD_LIMIT) begin
				$display("watchdog expired");
				$display("first_fit_boundary_tag_allocator_tb: done, errors");
				$finish;
			end
		end
	end

	function automatic heap_op_t mk(kind_t k, int sz, int ad);
		heap_op_t o;
		o.op = k;
		o.req_size = sz[15:0];
		o.addr = ad[15:0];
		return o;
	endfunction

	task automatic wait_drain();
		while (pending_ops.size() > 0 || pending_driven.size() > 0 || start
				|| expected_answers.size() > 0)
			@(posedge clk);
	endtask

	int r;
	initial begin
		heap_reset();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// Directed: zero size, small, odd sizes, split and exact fits, frees, a double
		// free, bad frees, a request too large for the heap, the maximum size.
		pending_ops.push_back(mk(KIND_ALLOC, 0, 0));
		pending_ops.push_back(mk(KIND_ALLOC, 1, 0));
		pending_ops.push_back(mk(KIND_ALLOC, 8, 0));
		pending_ops.push_back(mk(KIND_ALLOC, 9, 0));
		pending_ops.push_back(mk(KIND_ALLOC, 24, 0));
		pending_ops.push_back(mk(KIND_ALLOC, 100, 0));
		pending_ops.push_back(mk(KIND_FREE, 0, 24));
		pending_ops.push_back(mk(KIND_FREE, 0, 48));
		pending_ops.push_back(mk(KIND_FREE, 0, 16));
		pending_ops.push_back(mk(KIND_FREE, 0, 16));
		pending_ops.push_back(mk(KIND_FREE, 0, 3));
		pending_ops.push_back(mk(KIND_FREE, 0, 65535));
		pending_ops.push_back(mk(KIND_ALLOC, 16, 0));
		pending_ops.push_back(mk(KIND_ALLOC, 4080, 0));
		pending_ops.push_back(mk(KIND_ALLOC, 5000, 0));
		pending_ops.push_back(mk(KIND_ALLOC, 65535, 0));
		pending_ops.push_back(mk(KIND_ALLOC, 40000, 0));
		pending_ops.push_back(mk(KIND_ALLOC, 30000, 0));
		pending_ops.push_back(mk(KIND_FREE, 65535, 0));
		pending_ops.push_back(mk(KIND_FREE, 0, 0));
		wait_drain();
		// Random: mostly small allocations and frees of live blocks, some large and
		// zero-size requests, and frees of random addresses.
		for (int i = 0; i < 1000; i++) begin
			if (i == 300)
				no_idle = 1'b1;
			if (i == 500)
				no_idle = 1'b0;
			r = $urandom_range(99);
			if (r < 45)
				pending_ops.push_back(mk(KIND_ALLOC, $urandom_range(1, 200),
					$urandom_range(65535)));
			else if (r < 52)
				pending_ops.push_back(mk(KIND_ALLOC, $urandom_range(65535),
					$urandom_range(65535)));
			else if (r < 56)
				pending_ops.push_back(mk(KIND_ALLOC, 0, 0));
			else if (r < 92)
				pending_ops.push_back(mk(KIND_FREE, $urandom_range(65535), 0));
			else
				pending_ops.push_back(mk(KIND_FREE, $urandom_range(65535),
					$urandom_range(65535)));
			if (pending_ops.size() > 4)
				while (pending_ops.size() > 2)
					@(posedge clk);
		end
		wait_drain();
		repeat (50) @(posedge clk);
		$display("covered %0d allocations, %0d frees, %0d out-of-memory, %0d null requests",
			n_alloc, n_free, n_oom, n_null);
		if (errors == 0)
			$display("first_fit_boundary_tag_allocator_tb: done, clean");
		else
			$display("first_fit_boundary_tag_allocator_tb: done, errors");
		$finish;
	end

endmodule

`default_nettype wire

>>> first_fit_boundary_tag_allocator.f
src/ffa_pkg.sv
src/ffa_ram.sv
src/first_fit_boundary_tag_allocator.sv
test/first_fit_boundary_tag_allocator_tb.sv
